// ----- hdl/tiu_pkg.sv -----
// ----------------------------------------------------------------------------
// tiu_pkg
// Shared types and constants of the time interval union block.
// ----------------------------------------------------------------------------
package tiu_pkg;

  localparam int MaxIntervals = 64;
  localparam int TimeW        = 27;

  typedef struct packed {
    logic             occ;
    logic [TimeW-1:0] b;
    logic [TimeW-1:0] e;
  } entry_t;

  typedef enum logic [4:0] {
    ST_LOAD   = 5'b00001,
    ST_ONE    = 5'b00010,
    ST_TWO    = 5'b00100,
    ST_TWO_B  = 5'b01000,
    ST_MERGE  = 5'b10000
  } state_e;

endpackage

// ----- hdl/tiu_cell.sv -----
// ----------------------------------------------------------------------------
// tiu_cell
// One slot of the sorted insertion chain: keeps an entry ordered by begin,
// shifts right on insert, shifts left on pop.
// ----------------------------------------------------------------------------
module tiu_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  ins_i,
  input  logic [tiu_pkg::TimeW-1:0] key_b_i,
  input  logic [tiu_pkg::TimeW-1:0] key_e_i,
  input  logic                  pop_i,
  input  logic                  flush_i,
  input  tiu_pkg::entry_t       left_i,
  input  logic                  left_gt_i,
  input  tiu_pkg::entry_t       right_i,
  output tiu_pkg::entry_t       ent_o,
  output logic                  gt_o
);
  import tiu_pkg::*;

  logic             occ_q;
  logic [TimeW-1:0] b_q, e_q;
  entry_t           ent_q, ent_d;

  assign ent_q = {occ_q, b_q, e_q};

  // empty slot counts as larger than any key
  assign gt_o  = !ent_q.occ || (ent_q.b > key_b_i);
  assign ent_o = ent_q;

  always_comb begin
    ent_d = ent_q;
    if (flush_i) begin
      ent_d.occ = 1'b0;
    end else if (pop_i) begin
      ent_d = right_i;
    end else if (ins_i && gt_o) begin
      if (left_gt_i) begin
        ent_d = left_i;
      end else begin
        ent_d.occ = 1'b1;
        ent_d.b   = key_b_i;
        ent_d.e   = key_e_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= ent_d.occ;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q <= ent_d.b;
    e_q <= ent_d.e;
  end

endmodule

// ----- hdl/tiu_chain.sv -----
// ----------------------------------------------------------------------------
// tiu_chain
// Row of insertion cells; holds the valid intervals sorted by begin.
// ----------------------------------------------------------------------------
module tiu_chain #(
  parameter int MAX_INTERVALS = tiu_pkg::MaxIntervals
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      ins_i,
  input  logic [tiu_pkg::TimeW-1:0] key_b_i,
  input  logic [tiu_pkg::TimeW-1:0] key_e_i,
  input  logic                      pop_i,
  input  logic                      flush_i,
  output tiu_pkg::entry_t           head_o
);
  import tiu_pkg::*;

  entry_t ent   [MAX_INTERVALS];
  logic   gt    [MAX_INTERVALS];
  entry_t left  [MAX_INTERVALS];
  logic   lgt   [MAX_INTERVALS];
  entry_t right [MAX_INTERVALS];

  for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left[i] = '0;
      assign lgt[i]  = 1'b0;
    end else begin : g_mid
      assign left[i] = ent[i-1];
      assign lgt[i]  = gt[i-1];
    end
    if (i == MAX_INTERVALS - 1) begin : g_last
      assign right[i] = '0;
    end else begin : g_inner
      assign right[i] = ent[i+1];
    end

    tiu_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ins_i     (ins_i),
      .key_b_i   (key_b_i),
      .key_e_i   (key_e_i),
      .pop_i     (pop_i),
      .flush_i   (flush_i),
      .left_i    (left[i]),
      .left_gt_i (lgt[i]),
      .right_i   (right[i]),
      .ent_o     (ent[i]),
      .gt_o      (gt[i])
    );
  end

  assign head_o = ent[0];

endmodule

// ----- hdl/time_interval_union.sv -----
// ----------------------------------------------------------------------------
// time_interval_union
// Loads a set of intervals into a sorted insertion chain and emits their union.
// Loading: one interval beat per cycle; the chain insert completes in that cycle.
// After the last beat: input stalls while results drain; chain entries are
// popped in order and merged, output stalls hold the drain, and an empty chain
// yields one empty result. Sets of one or two use held copies instead of the
// chain. Each result is registered and shows in the cycle after its emit.
// Reset clears control state and chain occupancy; stored times are not reset.
// ----------------------------------------------------------------------------
module time_interval_union #(
  parameter int MAX_INTERVALS = tiu_pkg::MaxIntervals
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [tiu_pkg::TimeW-1:0] begin_ms_i,
  input  logic [tiu_pkg::TimeW-1:0] end_ms_i,
  input  logic                      times_present_i,
  input  logic                      is_last_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [tiu_pkg::TimeW-1:0] out_begin_ms_o,
  output logic [tiu_pkg::TimeW-1:0] out_end_ms_o,
  output logic                      out_present_o,
  output logic                      result_empty_o,
  output logic                      overflow_o,
  output logic                      last_result_o
);
  import tiu_pkg::*;

  localparam int CntW = $clog2(MAX_INTERVALS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_INTERVALS);

  state_e           state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic             has_q, has_d;
  logic [TimeW-1:0] cb_q, cb_d, ce_q, ce_d;
  logic [TimeW-1:0] r0b_q, r0e_q, r1b_q, r1e_q;
  logic             r0p_q, r1p_q;

  logic             ov_q, ov_d;
  logic [TimeW-1:0] ob_q, ob_d, oe_q, oe_d;
  logic             op_q, op_d, oem_q, oem_d, oovf_q, oovf_d, olast_q, olast_d;

  logic   in_acc, room, in_ok, ins, pop, flush, can_emit, emit, done;
  logic   v0, v1, isect;
  entry_t head;

  assign in_stall_o = (state_q != ST_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign room       = (cnt_q < CntMax);
  assign in_ok      = times_present_i && (begin_ms_i < end_ms_i);
  assign ins        = in_acc && room && in_ok;
  assign can_emit   = !ov_q || !out_stall_i;

  assign v0    = r0p_q && (r0b_q < r0e_q);
  assign v1    = r1p_q && (r1b_q < r1e_q);
  assign isect = (r0e_q >= r1b_q) && (r0b_q <= r1e_q);

  tiu_chain #(
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ins_i   (ins),
    .key_b_i (begin_ms_i),
    .key_e_i (end_ms_i),
    .pop_i   (pop),
    .flush_i (flush),
    .head_o  (head)
  );

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    has_d   = has_q;
    cb_d    = cb_q;
    ce_d    = ce_q;
    pop     = 1'b0;
    emit    = 1'b0;
    done    = 1'b0;
    ob_d    = '0;
    oe_d    = '0;
    op_d    = 1'b0;
    oem_d   = 1'b0;
    olast_d = 1'b0;

    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (room) begin
            cnt_d = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (is_last_i) begin
            cnt_d = '0;
            if (cnt_q == '0) begin
              state_d = ST_ONE;
            end else if ((cnt_q == CntW'(1)) || (!room && (cnt_q == CntW'(2)))) begin
              state_d = ST_TWO;
            end else begin
              state_d = ST_MERGE;
            end
          end
        end
      end
      ST_ONE: begin
        if (can_emit) begin
          emit    = 1'b1;
          ob_d    = r0b_q;
          oe_d    = r0e_q;
          op_d    = r0p_q;
          olast_d = 1'b1;
          done    = 1'b1;
        end
      end
      ST_TWO: begin
        if (can_emit) begin
          emit = 1'b1;
          op_d = 1'b1;
          done = 1'b1;
          olast_d = 1'b1;
          if (v0 && v1 && isect) begin
            ob_d = (r0b_q < r1b_q) ? r0b_q : r1b_q;
            oe_d = (r0e_q > r1e_q) ? r0e_q : r1e_q;
          end else if (v0) begin
            ob_d = r0b_q;
            oe_d = r0e_q;
            if (v1) begin
              olast_d = 1'b0;
              done    = 1'b0;
              state_d = ST_TWO_B;
            end
          end else if (v1) begin
            ob_d = r1b_q;
            oe_d = r1e_q;
          end else begin
            op_d  = 1'b0;
            oem_d = 1'b1;
          end
        end
      end
      ST_TWO_B: begin
        if (can_emit) begin
          emit    = 1'b1;
          ob_d    = r1b_q;
          oe_d    = r1e_q;
          op_d    = 1'b1;
          olast_d = 1'b1;
          done    = 1'b1;
        end
      end
      ST_MERGE: begin
        if (!has_q) begin
          if (head.occ) begin
            pop   = 1'b1;
            has_d = 1'b1;
            cb_d  = head.b;
            ce_d  = head.e;
          end else if (can_emit) begin
            emit    = 1'b1;
            oem_d   = 1'b1;
            olast_d = 1'b1;
            done    = 1'b1;
          end
        end else if (head.occ && (ce_q >= head.b)) begin
          pop = 1'b1;
          if (head.e > ce_q) begin
            ce_d = head.e;
          end
        end else if (can_emit) begin
          emit = 1'b1;
          ob_d = cb_q;
          oe_d = ce_q;
          op_d = 1'b1;
          if (head.occ) begin
            pop  = 1'b1;
            cb_d = head.b;
            ce_d = head.e;
          end else begin
            olast_d = 1'b1;
            done    = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase

    if (done) begin
      state_d = ST_LOAD;
      has_d   = 1'b0;
      ovf_d   = 1'b0;
    end
    oovf_d = ovf_q;
  end

  assign flush = done;

  always_comb begin
    ov_d = ov_q;
    if (emit) begin
      ov_d = 1'b1;
    end else if (!out_stall_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      has_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      has_q   <= has_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cb_q <= cb_d;
    ce_q <= ce_d;
    if (in_acc && (cnt_q == '0)) begin
      r0b_q <= begin_ms_i;
      r0e_q <= end_ms_i;
      r0p_q <= times_present_i;
    end
    if (in_acc && (cnt_q == CntW'(1))) begin
      r1b_q <= begin_ms_i;
      r1e_q <= end_ms_i;
      r1p_q <= times_present_i;
    end
    if (emit) begin
      ob_q    <= ob_d;
      oe_q    <= oe_d;
      op_q    <= op_d;
      oem_q   <= oem_d;
      oovf_q  <= oovf_d;
      olast_q <= olast_d;
    end
  end

  assign out_valid_o    = ov_q;
  assign out_begin_ms_o = ob_q;
  assign out_end_ms_o   = oe_q;
  assign out_present_o  = op_q;
  assign result_empty_o = oem_q;
  assign overflow_o     = oovf_q;
  assign last_result_o  = olast_q;

  a_last_returns_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && olast_d) |=> (state_q == ST_LOAD))
    else $error("last result did not return to load");

  a_chain_empty_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD && cnt_q == '0) |-> !head.occ)
    else $error("chain not empty at start of a set");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && oem_q) |-> olast_q)
    else $error("empty result not marked last");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax)
    else $error("load count beyond capacity");

  a_no_emit_while_loading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> !emit)
    else $error("result produced during load");

endmodule
